@@ src/conv2d_3x3_valid_stream_core_macros.svh @@
// Assertion macros shared by the convolution core modules
`ifndef CONV2D_3X3_VALID_STREAM_CORE_MACROS_SVH
`define CONV2D_3X3_VALID_STREAM_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define C2D_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define C2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define C2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/c2d_pkg.sv @@
// Shared constants and types of the 3x3 convolution core
`default_nettype none
package c2d_pkg;

    localparam int IMAGE_SIZE = 28;
    localparam int CNT_W      = $clog2(IMAGE_SIZE);

    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int KROW_W = 3 * COEF_W;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int ROW_W  = PROD_W + 2;
    localparam int SUM_W  = 36;

    // Output queue depth, power of two
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT = 2'd2;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    // [row: 0 oldest][col: 0 oldest]
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;
    typedef logic [2:0][KROW_W-1:0] t_kernel;

    typedef struct packed {
        logic             last;
        logic [SUM_W-1:0] sum;
    } t_ofifo_ent;

endpackage
`default_nettype wire

@@ src/c2d_in_if.sv @@
// Pixel input channel
`default_nettype none
interface c2d_in_if;
    import c2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source(output valid, output pixel, output frame_start, input ready);
    modport sink(input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

@@ src/c2d_out_if.sv @@
// Convolution result channel
`default_nettype none
interface c2d_out_if;
    import c2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] conv_sum;
    logic             frame_last;

    modport source(output valid, output conv_sum, output frame_last, input ready);
    modport sink(input valid, input conv_sum, input frame_last, output ready);
endinterface
`default_nettype wire

@@ src/c2d_ram.sv @@
// Generic simple dual-port RAM, registered read, read returns old data on collision
`default_nettype none
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ src/c2d_line_win.sv @@
// Position counters, line store read-modify-write and 3x3 window
`default_nettype none
`include "conv2d_3x3_valid_stream_core_macros.svh"
module c2d_line_win (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [c2d_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                  i_frame_start,
    output      logic                  o_claim,
    output      c2d_pkg::t_window      o_win,
    output      c2d_pkg::t_tag         o_tag
);
    import c2d_pkg::*;

    logic [CNT_W-1:0]   r_row, r_col;
    logic [CNT_W-1:0]   col_eff, row_eff;
    logic               produce, last_px, col_wrap;

    logic               r_s1_vld;
    t_tag               r_s1_tag;
    logic [PIX_W-1:0]   r_s1_px;
    logic [CNT_W-1:0]   r_s1_col;
    logic               r_fwd;
    logic               n_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;

    logic [2*PIX_W-1:0] ram_rdata, line, wdata;
    logic [PIX_W-1:0]   above_a, above_b;

    t_window            r_win;
    t_tag               r_tag;

    // Position of the pixel being accepted
    assign col_eff  = i_frame_start ? '0 : r_col;
    assign row_eff  = i_frame_start ? '0 : r_row;
    assign col_wrap = (col_eff == CNT_W'(IMAGE_SIZE - 1));
    assign produce  = (row_eff >= CNT_W'(2)) && (col_eff >= CNT_W'(2));
    assign last_px  = col_wrap && (row_eff == CNT_W'(IMAGE_SIZE - 1));
    assign o_claim  = i_take && produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_take) begin
            r_col <= col_wrap ? '0 : col_eff + CNT_W'(1);
            if (col_wrap) begin
                r_row <= (row_eff == CNT_W'(IMAGE_SIZE - 1)) ? '0 : row_eff + CNT_W'(1);
            end else begin
                r_row <= row_eff;
            end
        end
    end

    // Line store entry: {two rows above, one row above}
    c2d_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (IMAGE_SIZE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_re    (i_take),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    // Forward the write-back when the next beat reads the same column
    assign n_fwd   = i_take && r_s1_vld && (col_eff == r_s1_col);
    assign line    = r_fwd ? r_fwd_data : ram_rdata;
    assign above_a = line[PIX_W-1:0];
    assign above_b = line[2*PIX_W-1:PIX_W];
    assign wdata   = {above_a, r_s1_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_tag <= '0;
            r_fwd    <= 1'b0;
            r_tag    <= '0;
        end else begin
            r_s1_vld <= i_take;
            r_s1_tag <= '{vld: o_claim, last: o_claim && last_px};
            r_fwd    <= n_fwd;
            r_tag    <= r_s1_vld ? r_s1_tag : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wdata;
        if (i_take) begin
            r_s1_px  <= i_pixel;
            r_s1_col <= col_eff;
        end
    end

    // Shift the window left and bring in the new column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_vld) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= above_b;
            r_win[1][2] <= above_a;
            r_win[2][2] <= r_s1_px;
        end
    end

    assign o_win = r_win;
    assign o_tag = r_tag;

    `C2D_ASSERT_IMP(a_fwd_needs_s1, r_fwd, r_s1_vld, "forward flag without a beat in flight")
    `C2D_ASSERT_NXT(a_take_fills_s1, i_take, r_s1_vld, "accepted beat missing from stage one")
    `C2D_ASSERT(a_col_range, r_col < CNT_W'(IMAGE_SIZE), "column counter out of range")
endmodule
`default_nettype wire

@@ src/c2d_mac.sv @@
// Nine products and registered adder tree
`default_nettype none
module c2d_mac (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire c2d_pkg::t_window          i_win,
    input  wire c2d_pkg::t_tag             i_tag,
    input  wire c2d_pkg::t_kernel          i_kernel,
    output      logic [c2d_pkg::SUM_W-1:0] o_sum,
    output      c2d_pkg::t_tag             o_tag
);
    import c2d_pkg::*;

    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [ROW_W-1:0]  r_rsum [3];
    logic signed [SUM_W-1:0]  r_sum;
    t_tag                     r_tag_p, r_tag_r, r_tag_s;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= $signed(i_win[r][c])
                              * $signed(i_kernel[r][COEF_W*c +: COEF_W]);
            end
            r_rsum[r] <= ROW_W'(r_prod[r][0]) + ROW_W'(r_prod[r][1]) + ROW_W'(r_prod[r][2]);
        end
        r_sum <= SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_p <= '0;
            r_tag_r <= '0;
            r_tag_s <= '0;
        end else begin
            r_tag_p <= i_tag;
            r_tag_r <= r_tag_p;
            r_tag_s <= r_tag_r;
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag_s;
endmodule
`default_nettype wire

@@ src/c2d_ofifo.sv @@
// Result queue with credit count that throttles the input side
`default_nettype none
`include "conv2d_3x3_valid_stream_core_macros.svh"
module c2d_ofifo (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_claim,
    input  wire c2d_pkg::t_tag             i_push,
    input  wire logic [c2d_pkg::SUM_W-1:0] i_sum,
    output      logic                      o_room,
    c2d_out_if.source                      o_res
);
    import c2d_pkg::*;

    t_ofifo_ent          r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wp, r_rp;
    logic [OFIFO_AW:0]   r_cnt, r_credit;
    logic                pop;
    t_ofifo_ent          head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wp] <= '{last: i_push.last, sum: i_sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (i_push.vld) begin
                r_wp <= r_wp + OFIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OFIFO_AW'(1);
            end
            if (i_push.vld && !pop) begin
                r_cnt <= r_cnt + (OFIFO_AW+1)'(1);
            end else if (!i_push.vld && pop) begin
                r_cnt <= r_cnt - (OFIFO_AW+1)'(1);
            end
            if (i_claim && !pop) begin
                r_credit <= r_credit + (OFIFO_AW+1)'(1);
            end else if (!i_claim && pop) begin
                r_credit <= r_credit - (OFIFO_AW+1)'(1);
            end
        end
    end

    assign o_room           = r_credit < (OFIFO_AW+1)'(OFIFO_DEPTH);
    assign o_res.valid      = r_cnt != '0;
    assign o_res.conv_sum   = head.sum;
    assign o_res.frame_last = head.last;

    `C2D_ASSERT(a_cnt_le_credit, r_cnt <= r_credit, "queue holds more than was reserved")
    `C2D_ASSERT_IMP(a_push_reserved, i_push.vld, r_cnt < r_credit, "result pushed without a slot")
    `C2D_ASSERT_IMP(a_no_claim_full, !o_room, !i_claim, "beat claimed a slot while queue full")
endmodule
`default_nettype wire

@@ src/conv2d_3x3_valid_stream_core.sv @@
// 3x3 valid convolution core: top level
//
// Pixels of a square IMAGE_SIZE x IMAGE_SIZE image enter on i_px in raster order,
// one per beat; frame_start on a beat restarts the row and column count there.
// Once a pixel sits at row >= 2 and column >= 2 it yields one beat on o_res:
// the 36-bit Q15.20 sum of the 3x3 window times the kernel, frame_last set
// for the bottom right pixel. Other pixels yield nothing.
// The kernel rows are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the stream is idle, the core does not enforce it;
// index 0 is the top row, left coefficient in bits 15:0. Throughput is one pixel
// per cycle while the output queue has room. A pixel passes the line store read,
// window update, multiply, row sums and final sum, then enters the output queue.
// The two rows above live in one line store RAM, read and written back once
// per pixel, with a bypass when consecutive pixels hit the same column.
// A stalled receiver fills the 8-entry output queue; i_px.ready drops once
// every slot is reserved by a result in flight, so nothing is lost.
// Reset clears the counters, the window, the queue and the kernel; the line
// store needs no clearing and takes pixels right after reset.
`default_nettype none
module conv2d_3x3_valid_stream_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    c2d_in_if.sink                             i_px,
    c2d_out_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [c2d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [c2d_pkg::KROW_W-1:0]    i_cfg_data
);
    import c2d_pkg::*;

    t_kernel          r_kernel;
    logic             take, claim, room;
    t_window          win;
    t_tag             win_tag, sum_tag;
    logic [SUM_W-1:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KROW_TOP: r_kernel[0] <= i_cfg_data;
                CFG_KROW_MID: r_kernel[1] <= i_cfg_data;
                CFG_KROW_BOT: r_kernel[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_px.ready = room;
    assign take       = i_px.valid && room;

    c2d_line_win u_line_win (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_pixel       (i_px.pixel),
        .i_frame_start (i_px.frame_start),
        .o_claim       (claim),
        .o_win         (win),
        .o_tag         (win_tag)
    );

    c2d_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (win),
        .i_tag    (win_tag),
        .i_kernel (r_kernel),
        .o_sum    (sum),
        .o_tag    (sum_tag)
    );

    c2d_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_claim (claim),
        .i_push  (sum_tag),
        .i_sum   (sum),
        .o_room  (room),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire

@@ tb/tb_conv2d_3x3_valid_stream_core.sv @@
// Self-checking 3x3 valid conv core testbench: directed and random frames against a predictor
`timescale 1ns / 1ps
module tb_conv2d_3x3_valid_stream_core;
    import c2d_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int FRAME_PIXELS    = IMAGE_SIZE * IMAGE_SIZE;
    localparam int RANDOM_PIXELS   = 1100;
    localparam int SETTLE_CYCLES   = 12;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int KERN_MODES      = 6;

    // Index past the last kernel row; the core drops writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

    typedef enum int {
        KERN_MIN,
        KERN_MAX,
        KERN_ZERO,
        KERN_RANDOM,
        KERN_MIXED,
        KERN_CENTER
    } t_kern_mode;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_px_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [KROW_W-1:0]    cfg_data;

    c2d_in_if  px_if ();
    c2d_out_if res_if ();

    conv2d_3x3_valid_stream_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_px       (px_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state
    logic [PIX_W-1:0] row_one_up [IMAGE_SIZE] = '{default: '0};
    logic [PIX_W-1:0] row_two_up [IMAGE_SIZE] = '{default: '0};
    t_window          win_model  = '0;
    t_kernel          kern_model = '0;
    int unsigned      row_pos    = 0;
    int unsigned      col_pos    = 0;

    t_px_beat   pixels_to_send [$];
    t_ofifo_ent sums_due [$];

    bit          in_idle_on   = 1'b0;
    bit          out_idle_on  = 1'b0;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned px_gap_left  = 0;
    int unsigned res_gap_left = 0;
    int unsigned stuck_cycles = 0;
    int unsigned mismatch_count = 0;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] kernel_row(t_kern_mode mode, int unsigned r);
        logic [KROW_W-1:0] row;
        logic [COEF_W-1:0] coef;
        row = '0;
        for (int c = 0; c < 3; c++) begin
            case (mode)
                KERN_MIN:    coef = 16'h8000;
                KERN_MAX:    coef = 16'h7FFF;
                KERN_ZERO:   coef = 16'h0000;
                KERN_RANDOM: coef = COEF_W'($urandom());
                KERN_MIXED: begin
                    case ($urandom_range(0, 4))
                        0: coef = 16'h8000;
                        1: coef = 16'h7FFF;
                        2: coef = 16'h0000;
                        3: coef = 16'hFFFF;
                        default: coef = COEF_W'($urandom());
                    endcase
                end
                default:     coef = (r == 1 && c == 1) ? 16'h1000 : 16'h0000;
            endcase
            row[COEF_W*c +: COEF_W] = coef;
        end
        return row;
    endfunction

    // Shift the window, update the line stores, and queue the sum if the window is full
    function automatic void convolve_pixel(input logic [PIX_W-1:0] px, input logic start);
        longint     acc;
        t_ofifo_ent res;
        if (start) begin
            row_pos = 0;
            col_pos = 0;
        end
        for (int r = 0; r < 3; r++) begin
            win_model[r][0] = win_model[r][1];
            win_model[r][1] = win_model[r][2];
        end
        win_model[0][2] = row_two_up[col_pos];
        win_model[1][2] = row_one_up[col_pos];
        win_model[2][2] = px;
        row_two_up[col_pos] = row_one_up[col_pos];
        row_one_up[col_pos] = px;
        if (row_pos >= 2 && col_pos >= 2) begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    acc += longint'($signed(win_model[r][c]))
                         * longint'($signed(kern_model[r][COEF_W*c +: COEF_W]));
            res.sum  = acc[SUM_W-1:0];
            res.last = (row_pos == IMAGE_SIZE - 1) && (col_pos == IMAGE_SIZE - 1);
            sums_due.push_back(res);
        end
        col_pos++;
        if (col_pos == IMAGE_SIZE) begin
            col_pos = 0;
            row_pos = (row_pos + 1) % IMAGE_SIZE;
        end
    endfunction

    // Pixel driver
    always @(posedge i_clk) begin : drive_pixels
        t_px_beat beat;
        if (!i_rst_n) begin
            px_if.valid <= 1'b0;
            px_gap_left <= 0;
        end else begin
            if (px_if.valid && px_if.ready)
                convolve_pixel(px_if.pixel, px_if.frame_start);
            if (!px_if.valid || px_if.ready) begin
                if (px_gap_left != 0) begin
                    px_if.valid <= 1'b0;
                    px_gap_left <= px_gap_left - 1;
                end else if (pixels_to_send.size() != 0) begin
                    beat = pixels_to_send.pop_front();
                    px_if.valid       <= 1'b1;
                    px_if.pixel       <= beat.pixel;
                    px_if.frame_start <= beat.frame_start;
                    px_gap_left       <= in_idle_on ? pick_gap() : 0;
                end else begin
                    px_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin : check_results
        t_ofifo_ent want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_gap_left <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (sums_due.size() == 0) begin
                    $error("result beat with none expected: conv_sum %0d frame_last %0b",
                           $signed(res_if.conv_sum), res_if.frame_last);
                    mismatch_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (res_if.conv_sum !== want.sum) begin
                        $error("conv_sum: expected %0d, actual %0d",
                               $signed(want.sum), $signed(res_if.conv_sum));
                        mismatch_count++;
                    end
                    if (res_if.frame_last !== want.last) begin
                        $error("frame_last: expected %0b, actual %0b",
                               want.last, res_if.frame_last);
                        mismatch_count++;
                    end
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                hold_left    <= LONG_HOLD;
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else if (res_gap_left != 0) begin
                res_gap_left <= res_gap_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (out_idle_on && $urandom_range(0, 3) == 0)
                    res_gap_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (px_if.valid && px_if.ready) || (res_if.valid && res_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic start);
        t_px_beat beat;
        beat.pixel       = px;
        beat.frame_start = start;
        pixels_to_send.push_back(beat);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx <= CFG_KROW_BOT)
            kern_model[idx] = data;
    endtask

    task automatic load_kernel(input t_kern_mode mode);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        write_cfg(CFG_KROW_TOP, kernel_row(mode, 0));
        write_cfg(CFG_KROW_MID, kernel_row(mode, 1));
        write_cfg(CFG_KROW_BOT, kernel_row(mode, 2));
        write_cfg(CFG_IDX_NONE, junk[KROW_W-1:0]);
        @(negedge i_clk);
    endtask

    // Hold until every beat is sent and every sum is back, then let the pipeline empty
    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || px_if.valid || sums_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned frame_pos;
        logic        start;
        px_if.valid       = 1'b0;
        px_if.pixel       = '0;
        px_if.frame_start = 1'b0;
        res_if.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_KROW_TOP;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, restart mid-row, pixels that yield nothing
        push_pixel(16'h8000, 1'b1);
        push_pixel(16'h7FFF, 1'b0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h0001, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h1234, 1'b1);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h7FFF, 1'b1);
        push_pixel(16'h8001, 1'b0);
        push_pixel(16'h00FF, 1'b0);
        push_pixel(16'hFF00, 1'b0);
        wait_idle();

        // Random frames, the kernel changed between phases while idle
        sent      = 0;
        phase     = 0;
        frame_pos = 0;
        while (sent < RANDOM_PIXELS) begin
            load_kernel(t_kern_mode'(phase % KERN_MODES));
            in_idle_on  = (phase % 3) != 0;
            out_idle_on = (phase % 2) != 0;
            if (phase == 1)
                hold_req++;
            phase_len = $urandom_range(120, 260);
            for (int i = 0; i < phase_len && sent < RANDOM_PIXELS; i++) begin
                if (sent == 0)
                    start = 1'b1;
                else if (sent == FRAME_PIXELS)
                    start = 1'b0;  // let the counters wrap into the next frame
                else if (frame_pos == 0)
                    start = $urandom_range(0, 1);
                else if (sent > FRAME_PIXELS)
                    start = ($urandom_range(0, 149) == 0);
                else
                    start = 1'b0;
                if (start)
                    frame_pos = 0;
                push_pixel(random_pixel(), start);
                frame_pos = (frame_pos + 1) % FRAME_PIXELS;
                sent++;
            end
            wait_idle();
            phase++;
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/c2d_pkg.sv
src/c2d_in_if.sv
src/c2d_out_if.sv
src/c2d_ram.sv
src/c2d_line_win.sv
src/c2d_mac.sv
src/c2d_ofifo.sv
src/conv2d_3x3_valid_stream_core.sv
tb/tb_conv2d_3x3_valid_stream_core.sv
